@@ sv/rgbc_pkg.sv @@
package rgbc_pkg;

   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned PixWidth   = 3 * ChanWidth;
   localparam int unsigned CoefWidth  = 16;
   localparam int unsigned RowRegWidth = 3 * CoefWidth;
   localparam int unsigned CsrDataWidth = 48;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned TapWidth   = CoefWidth + ChanWidth + 1;
   localparam int unsigned AccWidth   = TapWidth + 4;
   localparam int unsigned FracBits   = 10;

   localparam logic [CsrIdxWidth-1:0] RegCoefTop    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegCoefMid    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegCoefBottom = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegFrameWidth = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegFrameHeight = 3'd4;

   localparam logic CmdPixel = 1'b0;
   localparam logic CmdFlush = 1'b1;

   typedef logic [PixWidth-1:0] pix_type;

   // Per-item control handed from stage 1 through the window stage to the multiply-add.
   typedef struct packed {
      logic valid;
      logic frame_end;
      logic [8:0] use_tap;
   } ctl_type;

   // One filtered pixel.
   typedef struct packed {
      logic [ChanWidth-1:0] blue;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] red;
   } rgb_type;

   function automatic logic [ChanWidth-1:0] clamp_chan(input logic signed [AccWidth-1:0] acc);
      logic signed [AccWidth-1:0] q;
      begin
         q = acc >>> FracBits;
         if (acc < 0) begin
            clamp_chan = '0;
         end else if (q > 255) begin
            clamp_chan = 8'hff;
         end else begin
            clamp_chan = q[ChanWidth-1:0];
         end
      end
   endfunction

endpackage

@@ sv/rgbc_line_store.sv @@
module rgbc_line_store #(
   parameter int unsigned Depth = 1024,
   parameter int unsigned AddrWidth = 10
) (
   input  logic clock,
   input  logic rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output rgbc_pkg::pix_type rd_data,
   input  logic wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  rgbc_pkg::pix_type wr_data
);

   rgbc_pkg::pix_type mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ sv/rgbc_tap_cell.sv @@
// One window column cell: holds three pixels and passes them to its neighbor
// when the window advances.
module rgbc_tap_cell (
   input  logic clock,
   input  logic shift,
   input  rgbc_pkg::pix_type top_in,
   input  rgbc_pkg::pix_type mid_in,
   input  rgbc_pkg::pix_type bot_in,
   output rgbc_pkg::pix_type top_ff,
   output rgbc_pkg::pix_type mid_ff,
   output rgbc_pkg::pix_type bot_ff
);

   always_ff @(posedge clock) begin
      if (shift) begin
         top_ff <= top_in;
         mid_ff <= mid_in;
         bot_ff <= bot_in;
      end
   end

endmodule

@@ sv/rgbc_mac.sv @@
// Multiply-add of the nine taps for all three channels, two register stages.
module rgbc_mac (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  rgbc_pkg::ctl_type ctl_in,
   input  rgbc_pkg::pix_type taps [9],
   input  logic [rgbc_pkg::RowRegWidth-1:0] coef_top,
   input  logic [rgbc_pkg::RowRegWidth-1:0] coef_mid,
   input  logic [rgbc_pkg::RowRegWidth-1:0] coef_bot,
   output logic valid_ff,
   output logic frame_end_ff,
   output rgbc_pkg::rgb_type rgb_ff
);

   localparam int unsigned TW = rgbc_pkg::TapWidth;
   localparam int unsigned AW = rgbc_pkg::AccWidth;

   logic signed [TW-1:0] prod_ff [9][3];
   logic signed [TW-1:0] prod_in [9][3];
   logic p_valid_ff, p_end_ff;
   logic signed [AW-1:0] sum [3];

   always_comb begin
      logic [rgbc_pkg::RowRegWidth-1:0] reg_sel;
      logic signed [rgbc_pkg::CoefWidth-1:0] k;
      rgbc_pkg::pix_type p;
      for (int i = 0; i < 9; i++) begin
         reg_sel = (i < 3) ? coef_top : ((i < 6) ? coef_mid : coef_bot);
         k = reg_sel[(i % 3) * rgbc_pkg::CoefWidth +: rgbc_pkg::CoefWidth];
         p = ctl_in.use_tap[i] ? taps[i] : taps[4];
         for (int c = 0; c < 3; c++) begin
            prod_in[i][c] = TW'(k * $signed({1'b0, p[c * 8 +: 8]}));
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = '0;
         for (int i = 0; i < 9; i++) begin
            sum[c] = sum[c] + AW'(prod_ff[i][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         p_end_ff     <= 1'b0;
         valid_ff     <= 1'b0;
         frame_end_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff   <= ctl_in.valid;
         p_end_ff     <= ctl_in.frame_end;
         valid_ff     <= p_valid_ff;
         frame_end_ff <= p_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         rgb_ff.red   <= rgbc_pkg::clamp_chan(sum[0]);
         rgb_ff.green <= rgbc_pkg::clamp_chan(sum[1]);
         rgb_ff.blue  <= rgbc_pkg::clamp_chan(sum[2]);
      end
   end

endmodule

@@ sv/rgb_conv3x3_center_border.sv @@
// A pixel's result leaves once the item that completes its neighborhood (the item
// one row plus one pixel later) has passed stage 1, the window and the multiply-add.
// Throughput: one item per cycle; the line store read port and the window shift
// advance once per item taken (not on an ignored early flush), and the pipeline stalls as a whole.
// Reset clears counters and window valid state and sets the configuration registers
// to their defaults; the line stores hold no reset value.
module rgb_conv3x3_center_border #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_cmd,
   input  logic [7:0] req_in_red,
   input  logic [7:0] req_in_green,
   input  logic [7:0] req_in_blue,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic rsp_frame_end,
   input  logic csr_write,
   input  logic [rgbc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [rgbc_pkg::CsrDataWidth-1:0] csr_data
);

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

   // Configuration registers.
   logic [47:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [10:0] width_reg_ff;
   logic [12:0] height_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff   <= '0;
         coef_mid_ff   <= 48'd67108864;
         coef_bot_ff   <= '0;
         width_reg_ff  <= 11'd640;
         height_reg_ff <= 13'd480;
      end else if (csr_write) begin
         unique case (csr_index)
            rgbc_pkg::RegCoefTop:     coef_top_ff   <= csr_data;
            rgbc_pkg::RegCoefMid:     coef_mid_ff   <= csr_data;
            rgbc_pkg::RegCoefBottom:  coef_bot_ff   <= csr_data;
            rgbc_pkg::RegFrameWidth:  width_reg_ff  <= csr_data[10:0];
            rgbc_pkg::RegFrameHeight: height_reg_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Size clamped to 1..MAX.
   logic [WW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   always_comb begin
      if (width_reg_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_reg_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         h_eff = RW'(1);
      end else if (32'(height_reg_ff) > MAX_HEIGHT) begin
         h_eff = RW'(MAX_HEIGHT);
      end else begin
         h_eff = RW'(height_reg_ff);
      end
   end

   // Pipeline moves whenever the output slot is free or being emptied.
   logic advance;
   logic accept;
   logic mac_valid;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   // Input position counters.
   logic [WW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [WW-1:0] col;
   logic [RW-1:0] row;
   logic in_frame, active, emit, last_out, drop;
   logic [RW:0] cr;
   logic [WW-1:0] cc;

   always_comb begin
      col = col_ff;
      row = row_ff;
      if (col_ff >= w_eff) begin
         col = '0;
         row = row_ff + 1'b1;
      end
      in_frame = row < h_eff;
      active   = accept && !(req_cmd == rgbc_pkg::CmdFlush && in_frame);
      emit     = (row >= RW'(2)) || (row == RW'(1) && col != '0);
      if (col != '0) begin
         cr = (RW + 1)'(row) - 1'b1;
         cc = col - 1'b1;
      end else begin
         cr = (RW + 1)'(row) - 2'd2;
         cc = w_eff - 1'b1;
      end
      drop     = emit && (cr >= (RW + 1)'(h_eff));
      last_out = emit && !drop && cr == (RW + 1)'(h_eff) - 1'b1 && cc == w_eff - 1'b1;
   end

   // An early flush changes nothing except that a column count left past a
   // narrowed width is wrapped to the next row.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (active) begin
         if (drop || last_out) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col + 1'b1 >= w_eff) begin
            col_ff <= '0;
            row_ff <= row + 1'b1;
         end else begin
            col_ff <= col + 1'b1;
            row_ff <= row;
         end
      end else if (accept) begin
         col_ff <= col;
         row_ff <= row;
      end
   end

   // Stage 1: line stores read, incoming pixel and control registered.
   rgbc_pkg::pix_type pix;
   assign pix = in_frame ? {req_in_blue, req_in_green, req_in_red} : '0;

   rgbc_pkg::pix_type up_rd, lo_rd;
   rgbc_pkg::pix_type pix_s1_ff;
   logic [CW-1:0] col_addr;
   assign col_addr = col[CW-1:0];

   logic s1_valid_ff;
   logic s1_go;
   logic [CW-1:0] s1_addr_ff;
   rgbc_pkg::ctl_type s1_ctl_ff, s1_ctl_in;

   // Stage 1 holds its item while the output stalls and moves on with it.
   assign s1_go = s1_valid_ff && advance;

   // Each line store is read as the item is taken; the value read is also what
   // moves to the upper store, so the lower read feeds the upper write.
   rgbc_line_store #(.Depth(MAX_WIDTH), .AddrWidth(CW)) u_upper (
      .clock(clock), .rd_en(active), .rd_addr(col_addr), .rd_data(up_rd),
      .wr_en(s1_go), .wr_addr(s1_addr_ff), .wr_data(lo_rd)
   );
   rgbc_line_store #(.Depth(MAX_WIDTH), .AddrWidth(CW)) u_lower (
      .clock(clock), .rd_en(active), .rd_addr(col_addr), .rd_data(lo_rd),
      .wr_en(active), .wr_addr(col_addr), .wr_data(pix)
   );

   always_comb begin
      logic signed [RW+1:0] nr;
      logic signed [WW+1:0] nc;
      s1_ctl_in.valid     = active && emit && !drop;
      s1_ctl_in.frame_end = last_out;
      for (int i = 0; i < 9; i++) begin
         nr = $signed({1'b0, cr}) + (RW + 2)'(i / 3) - (RW + 2)'(1);
         nc = $signed({2'b0, cc}) + (WW + 2)'(i % 3) - (WW + 2)'(1);
         s1_ctl_in.use_tap[i] = nr >= 0 && nr < $signed({2'b0, h_eff})
                                && nc >= 0 && nc < $signed({2'b0, w_eff});
      end
   end

   // A read-after-write hazard exists when a column is read in the same cycle as its
   // stage 1 write to the upper store; with width one the read is forwarded.
   logic fwd_ff;
   rgbc_pkg::pix_type fwd_lo_ff, fwd_up_ff;
   rgbc_pkg::pix_type up_col, lo_col;
   always_comb begin
      up_col = fwd_ff ? fwd_up_ff : up_rd;
      lo_col = fwd_ff ? fwd_lo_ff : lo_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= active;
         fwd_ff      <= active && s1_valid_ff && s1_addr_ff == col_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         s1_addr_ff <= col_addr;
         pix_s1_ff  <= pix;
         s1_ctl_ff  <= s1_ctl_in;
         fwd_lo_ff  <= pix_s1_ff;
         fwd_up_ff  <= lo_col;
      end
   end

   // The window: three cells, each one column of three pixels, shifting left.
   rgbc_pkg::pix_type win [3][3];
   logic shift;
   assign shift = s1_go;

   rgbc_tap_cell u_cell2 (
      .clock(clock), .shift(shift),
      .top_in(up_col), .mid_in(lo_col), .bot_in(pix_s1_ff),
      .top_ff(win[2][0]), .mid_ff(win[2][1]), .bot_ff(win[2][2])
   );
   rgbc_tap_cell u_cell1 (
      .clock(clock), .shift(shift),
      .top_in(win[2][0]), .mid_in(win[2][1]), .bot_in(win[2][2]),
      .top_ff(win[1][0]), .mid_ff(win[1][1]), .bot_ff(win[1][2])
   );
   rgbc_tap_cell u_cell0 (
      .clock(clock), .shift(shift),
      .top_in(win[1][0]), .mid_in(win[1][1]), .bot_in(win[1][2]),
      .top_ff(win[0][0]), .mid_ff(win[0][1]), .bot_ff(win[0][2])
   );

   logic w_valid_ff;
   rgbc_pkg::ctl_type w_ctl_ff, mac_ctl;
   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else if (advance) begin
         w_valid_ff <= s1_valid_ff && s1_ctl_ff.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         w_ctl_ff <= s1_ctl_ff;
      end
   end

   rgbc_pkg::pix_type taps [9];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            taps[r * 3 + c] = win[c][r];
         end
      end
      mac_ctl       = w_ctl_ff;
      mac_ctl.valid = w_valid_ff;
   end

   rgbc_pkg::rgb_type rgb;
   logic mac_end;
   rgbc_mac u_mac (
      .clock(clock), .reset(reset), .advance(advance), .ctl_in(mac_ctl), .taps(taps),
      .coef_top(coef_top_ff), .coef_mid(coef_mid_ff), .coef_bot(coef_bot_ff),
      .valid_ff(mac_valid), .frame_end_ff(mac_end), .rgb_ff(rgb)
   );

   assign rsp_valid     = mac_valid;
   assign rsp_out_red   = rgb.red;
   assign rsp_out_green = rgb.green;
   assign rsp_out_blue  = rgb.blue;
   assign rsp_frame_end = mac_end;

   // A stalled result must hold its frame marker.
   a_hold_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_frame_end))
      else $error("frame_end changed under stall");

   // The column counter never passes the largest width.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= WW'(MAX_WIDTH))
      else $error("column counter out of range");

   // No item is taken while the output is stalled.
   a_no_accept_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted during stall");

endmodule

@@ dv/tb_rgb_conv3x3_center_border.sv @@
module tb_rgb_conv3x3_center_border;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LineDepth = 1024;
   localparam int unsigned HeightCap = 4096;
   localparam int unsigned SettleCycles = 20;
   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned RandomItems = 1000;

   // One input item as offered on the request channel.
   typedef struct packed {
      logic cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_item_type;

   // One expected filtered pixel with its end-of-frame flag.
   typedef struct packed {
      rgbc_pkg::rgb_type rgb;
      logic frame_end;
   } filtered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = rgbc_pkg::CmdPixel;
   logic [7:0] req_in_red = '0;
   logic [7:0] req_in_green = '0;
   logic [7:0] req_in_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic rsp_frame_end;
   logic csr_write = 1'b0;
   logic [rgbc_pkg::CsrIdxWidth-1:0] csr_index = rgbc_pkg::RegCoefTop;
   logic [rgbc_pkg::CsrDataWidth-1:0] csr_data = '0;

   rgb_conv3x3_center_border dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Items waiting for the driver and filtered pixels waiting for the block.
   pixel_item_type pending_pixels[$];
   filtered_type expected_pixels[$];

   int unsigned mismatches = 0;
   int unsigned items_taken = 0;
   int unsigned items_accepted = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;
   bit no_gaps = 1'b0;

   // Shadow state of the filter: registers, line stores, window and counters.
   logic [47:0] coef_row[3];
   logic [10:0] width_reg;
   logic [12:0] height_reg;
   logic [23:0] upper_line[LineDepth];
   logic [23:0] lower_line[LineDepth];
   logic [23:0] win[9];
   int unsigned row_cnt;
   int unsigned col_cnt;
   bit frame_open;

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LineDepth) return LineDepth;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > HeightCap) return HeightCap;
      return height_reg;
   endfunction

   function automatic logic [7:0] floor_clamp(input longint acc);
      longint q;
      q = acc >>> rgbc_pkg::FracBits;
      if (acc < 0) return 8'h00;
      if (q > 255) return 8'hff;
      return q[7:0];
   endfunction

   // Advances the shadow filter by one item. The item is either ignored
   // (an early flush), taken without a result, or taken with one result.
   task automatic filter_step(input pixel_item_type item, output bit taken,
                              output bit has_res, output filtered_type res);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      logic [23:0] pix;
      logic [23:0] p;
      longint cr;
      longint cc;
      longint nr;
      longint nc;
      longint k;
      longint acc[3];
      bit emit;
      taken = 1'b0;
      has_res = 1'b0;
      res = '0;
      w = eff_width();
      h = eff_height();
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
      end
      col = col_cnt;
      row = row_cnt;
      // A flush is ignored while pixels of the frame are still due.
      if (item.cmd == rgbc_pkg::CmdFlush && row < h) return;
      taken = 1'b1;
      frame_open = 1'b1;
      // Past the last row a pixel command acts as a flush; its data is dropped.
      pix = (row < h) ? {item.blue, item.green, item.red} : 24'h0;
      for (int r = 0; r < 3; r++) begin
         win[r*3] = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = upper_line[col];
      win[5] = lower_line[col];
      win[8] = pix;
      upper_line[col] = lower_line[col];
      lower_line[col] = pix;
      emit = (row >= 2) || (row == 1 && col >= 1);
      if (col >= 1) begin
         cr = longint'(row) - 1;
         cc = longint'(col) - 1;
      end else begin
         cr = longint'(row) - 2;
         cc = longint'(w) - 1;
      end
      col_cnt = col + 1;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt = row + 1;
      end
      if (!emit) return;
      if (cr >= longint'(h)) begin
         // The frame shrank below the center row: restart without a result.
         row_cnt = 0;
         col_cnt = 0;
         frame_open = 1'b0;
         return;
      end
      acc[0] = 0;
      acc[1] = 0;
      acc[2] = 0;
      for (int i = 0; i < 9; i++) begin
         nr = cr + i / 3 - 1;
         nc = cc + i % 3 - 1;
         // Neighbors outside the frame take the center pixel's value.
         p = win[4];
         if (nr >= 0 && nr < longint'(h) && nc >= 0 && nc < longint'(w)) p = win[i];
         k = longint'($signed(coef_row[i/3][16*(i%3) +: 16]));
         for (int ch = 0; ch < 3; ch++) acc[ch] += k * longint'(p[8*ch +: 8]);
      end
      has_res = 1'b1;
      res.rgb.red = floor_clamp(acc[0]);
      res.rgb.green = floor_clamp(acc[1]);
      res.rgb.blue = floor_clamp(acc[2]);
      res.frame_end = (cr == longint'(h) - 1) && (cc == longint'(w) - 1);
      if (res.frame_end) begin
         row_cnt = 0;
         col_cnt = 0;
         frame_open = 1'b0;
      end
   endtask

   function automatic logic [7:0] pick_chan();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // Predicts the item, queues it for the driver, and queues its result.
   task automatic send_item(input logic cmd);
      pixel_item_type item;
      bit taken;
      bit has_res;
      filtered_type res;
      item.cmd = cmd;
      item.red = pick_chan();
      item.green = pick_chan();
      item.blue = pick_chan();
      filter_step(item, taken, has_res, res);
      if (taken) items_taken++;
      pending_pixels.push_back(item);
      if (has_res) expected_pixels.push_back(res);
   endtask

   task automatic send_pixels(input int unsigned n);
      repeat (n) send_item(rgbc_pkg::CmdPixel);
   endtask

   // Feeds the rest of the frame until the last result clears the counters.
   // Early flushes and pixel commands in the flush phase are mixed in.
   task automatic finish_frame(input int unsigned pixel_in_flush_pct);
      bit seen_open;
      int unsigned w;
      int unsigned row_eff;
      seen_open = frame_open;
      while (!seen_open || frame_open) begin
         w = eff_width();
         row_eff = (col_cnt >= w) ? row_cnt + 1 : row_cnt;
         if (row_eff < eff_height()) begin
            if ($urandom_range(0, 99) < 8) send_item(rgbc_pkg::CmdFlush);
            else send_item(rgbc_pkg::CmdPixel);
         end else if ($urandom_range(0, 99) < pixel_in_flush_pct) begin
            send_item(rgbc_pkg::CmdPixel);
         end else begin
            send_item(rgbc_pkg::CmdFlush);
         end
         if (frame_open) seen_open = 1'b1;
      end
   endtask

   // Waits until every item has been taken and every result has come back,
   // then lets the pipeline settle so that results-free items are done too.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rgbc_pkg::CsrIdxWidth-1:0] idx,
                            input logic [47:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         rgbc_pkg::RegCoefTop: coef_row[0] = value;
         rgbc_pkg::RegCoefMid: coef_row[1] = value;
         rgbc_pkg::RegCoefBottom: coef_row[2] = value;
         rgbc_pkg::RegFrameWidth: width_reg = value[10:0];
         rgbc_pkg::RegFrameHeight: height_reg = value[12:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] small_coef();
      return 16'($signed($urandom_range(0, 2048)) - 1024);
   endfunction

   task automatic write_kernel();
      logic [47:0] row_val[3];
      int unsigned mode;
      mode = $urandom_range(0, 3);
      for (int r = 0; r < 3; r++) begin
         if (mode == 0) row_val[r] = 48'({$urandom, $urandom});
         else row_val[r] = {small_coef(), small_coef(), small_coef()};
      end
      // A mostly positive center keeps the outputs away from the clamps.
      if (mode >= 2) row_val[1][31:16] = 16'($urandom_range(0, 1536));
      write_reg(rgbc_pkg::RegCoefTop, row_val[0]);
      write_reg(rgbc_pkg::RegCoefMid, row_val[1]);
      write_reg(rgbc_pkg::RegCoefBottom, row_val[2]);
   endtask

   task automatic write_size(input int unsigned w, input int unsigned h);
      write_reg(rgbc_pkg::RegFrameWidth, 48'(w));
      write_reg(rgbc_pkg::RegFrameHeight, 48'(h));
   endtask

   // Driver: offers the next pending item, with random gaps between items.
   always @(posedge clock) begin
      pixel_item_type nxt;
      bit go;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) items_accepted <= items_accepted + 1;
         go = pending_pixels.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 25);
         if (go) begin
            nxt = pending_pixels.pop_front();
            req_valid <= 1'b1;
            req_cmd <= nxt.cmd;
            req_in_red <= nxt.red;
            req_in_green <= nxt.green;
            req_in_blue <= nxt.blue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // One long receiver hold-off once the run is well under way, started while
   // plenty of items are still queued, so that the pipeline fills and
   // back-pressures the request channel.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_accepted >= 600 && pending_pixels.size() > 16) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, what);
   endfunction

   // Monitor: checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      filtered_type exp_px;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               note_mismatch($sformatf("unexpected item r=%0d g=%0d b=%0d end=%0d",
                  rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end));
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_out_red !== exp_px.rgb.red || rsp_out_green !== exp_px.rgb.green ||
                   rsp_out_blue !== exp_px.rgb.blue || rsp_frame_end !== exp_px.frame_end) begin
                  note_mismatch($sformatf(
                     "expected r=%0d g=%0d b=%0d end=%0d, got r=%0d g=%0d b=%0d end=%0d",
                     exp_px.rgb.red, exp_px.rgb.green, exp_px.rgb.blue, exp_px.frame_end,
                     rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end));
               end
            end
         end
         rsp_ready <= (hold_left == 0) && (no_gaps || $urandom_range(0, 99) >= 25);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("rgb_conv3x3_center_border: mismatch");
         $finish;
      end
   end

   initial begin
      int unsigned frame_idx;
      coef_row[0] = 48'h0;
      coef_row[1] = 48'd67108864;
      coef_row[2] = 48'h0;
      width_reg = 11'd640;
      height_reg = 13'd480;
      for (int i = 0; i < 9; i++) win[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
      frame_open = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First a small frame with the reset kernel, opened by a
      // flush that comes too early and with another early flush mid-frame.
      write_size(2, 3);
      send_item(rgbc_pkg::CmdFlush);
      send_pixels(3);
      send_item(rgbc_pkg::CmdFlush);
      finish_frame(50);
      wait_idle();
      // Width and height registers at zero mean a single-pixel frame.
      write_kernel();
      write_size(0, 0);
      finish_frame(50);
      wait_idle();
      // A wide frame, with the most negative and most positive coefficients.
      write_reg(rgbc_pkg::RegCoefTop, 48'h8000_8000_8000);
      write_reg(rgbc_pkg::RegCoefMid, 48'h7fff_7fff_7fff);
      write_reg(rgbc_pkg::RegCoefBottom, 48'hffff_0000_ffff);
      write_size(40, 2);
      finish_frame(30);
      wait_idle();
      // The height shrinks mid-frame below the row being filtered, so the
      // counters restart without a result.
      write_kernel();
      write_size(3, 8191);
      send_pixels(7);
      wait_idle();
      write_reg(rgbc_pkg::RegFrameHeight, 48'd1);
      finish_frame(50);
      wait_idle();
      // The width shrinks mid-frame; the column count wraps early.
      write_size(5, 4);
      send_pixels(12);
      wait_idle();
      write_reg(rgbc_pkg::RegFrameWidth, 48'd3);
      finish_frame(30);
      wait_idle();
      // A tall frame, one pixel wide.
      write_kernel();
      write_size(1, 300);
      finish_frame(30);
      wait_idle();

      // Random part: small frames, kernels and sizes changed between frames,
      // sometimes frames back to back with no pause in between.
      frame_idx = 0;
      items_taken = 0;
      while (items_taken < RandomItems) begin
         if (frame_idx == 10) no_gaps <= 1'b1;
         if (frame_idx == 20) no_gaps <= 1'b0;
         if (frame_idx == 0 || $urandom_range(0, 2) != 0) begin
            wait_idle();
            if ($urandom_range(0, 1) == 0) write_kernel();
            if ($urandom_range(0, 7) == 0) write_size($urandom_range(0, 40), $urandom_range(0, 12));
            else write_size($urandom_range(0, 12), $urandom_range(0, 8));
         end
         finish_frame($urandom_range(0, 40));
         frame_idx++;
      end

      wait_idle();
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("rgb_conv3x3_center_border: match");
      end else begin
         $display("rgb_conv3x3_center_border: mismatch");
      end
      $finish;
   end

endmodule
